// ===== design/assert_macros.svh =====
// Assertion macros shared by the event word unpacker.
// Each macro checks on the rising clock edge and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DWEU_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define DWEU_ASSERT_NXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/dweu_pkg.sv =====
// Shared types and constants of the digitizer event word unpacker.
// Used by the controller, the datapath and the top level; depends on nothing.
package dweu_pkg;

   localparam int MAX_SAMPLES  = 65536;
   localparam int NUM_CHANNELS = 8;

   localparam int WORD_W    = 32;
   localparam int SIZE_W    = 28;
   localparam int MASK_W    = 8;
   localparam int CH_W      = 3;
   localparam int ID_W      = 23;
   localparam int IDX_W     = 16;
   localparam int VAL_W     = 16;
   localparam int KIND_W    = 3;
   localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int DIV_CNT_W = $clog2(SIZE_W);
   localparam int NCH_W     = 4;
   localparam int REM_W     = 3;
   localparam int RSP_W     = 104;

   localparam logic [3:0]        HDR_MARKER = 4'hA;
   localparam logic [SIZE_W-1:0] HDR_WORDS  = SIZE_W'(4);
   localparam logic [MASK_W-1:0] CH_MASK    = MASK_W'((1 << NUM_CHANNELS) - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER     = 3'd0,
      KIND_SAMPLE     = 3'd1,
      KIND_BAD_HEADER = 3'd2,
      KIND_EMPTY_MASK = 3'd3,
      KIND_OVERFLOW   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_HDR1,
      ST_HDR2,
      ST_DIV,
      ST_HDR3,
      ST_HDR4,
      ST_DATA,
      ST_EMIT,
      ST_STOP
   } state_type;

   typedef struct packed {
      logic     hdr1_load;
      logic     hdr2_load;
      logic     div_step;
      logic     hdr3_load;
      logic     hdr4_load;
      logic     data_load;
      logic     emit_step;
      logic     word_end;
      logic     out_load;
      kind_type out_kind;
      logic     out_last;
   } cmd_type;

   typedef struct packed {
      logic marker_ok;
      logic nch_zero;
      logic div_last;
      logic wpc_zero;
      logic out_free;
      logic slot_none;
      logic slot_last;
      logic overflow;
      logic event_end;
   } sts_type;

endpackage

// ===== design/digitizer_event_word_unpacker.sv =====
// Each header word is taken when the result register is free; the header result is valid the
// cycle after word four. The second header word starts a serial divide of the 28-bit payload
// size by the channel count (one quotient bit per cycle) before word three is taken. A payload
// word is taken, then its results (two in mode 0, zero to three in mode 1) leave one by one
// through the one result register. Synchronous active-high reset returns to the first header
// word and clears packing mode to 0; after an error result the block drops every beat until reset.
`include "assert_macros.svh"

module digitizer_event_word_unpacker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dweu_pkg::WORD_W-1:0]    req_tdata,   // data_word
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_data,    // packing_mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // channel[2:0], sample_index[18:3], sample_value[34:19], event_id[57:35],
   // time_stamp[89:58], channel_mask[97:90], zero fill above
   output logic [dweu_pkg::RSP_W-1:0]     rsp_tdata,
   output logic [dweu_pkg::KIND_W-1:0]    rsp_tuser,   // kind
   output logic                           rsp_tlast    // last
);

   dweu_pkg::cmd_type cmd;
   dweu_pkg::sts_type sts;
   logic              err_valid;
   logic              err_done;
   logic              bad_valid;
   logic              smp_valid;

   assign csr_ready = 1'b1;

   dweu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dweu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign err_valid = rsp_tvalid && (rsp_tuser inside {dweu_pkg::KIND_BAD_HEADER,
                                                       dweu_pkg::KIND_EMPTY_MASK,
                                                       dweu_pkg::KIND_OVERFLOW});
   assign err_done  = err_valid && rsp_tready;
   assign bad_valid = rsp_tvalid && (rsp_tuser == dweu_pkg::KIND_BAD_HEADER);
   assign smp_valid = rsp_tvalid && (rsp_tuser == dweu_pkg::KIND_SAMPLE);

   `DWEU_ASSERT_IMP(a_error_is_last, err_valid, rsp_tlast, "error result without last")
   `DWEU_ASSERT_NXT(a_stop_after_error, err_done, !rsp_tvalid, "result after an error")
   `DWEU_ASSERT_IMP(a_bad_header_clear, bad_valid, rsp_tdata == '0, "bad header with context")
   `DWEU_ASSERT_IMP(a_sample_fill, smp_valid, rsp_tdata[103:98] == 6'b0, "fill bits set")

endmodule

// ===== design/dweu_ctrl.sv =====
// Controller of the event word unpacker: walks header, divide, payload and stop phases.
// Uses dweu_pkg; drives datapath commands and the input ready.
module dweu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  dweu_pkg::sts_type sts,
   output dweu_pkg::cmd_type cmd
);

   dweu_pkg::state_type state_ff, state_in;
   logic                in_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dweu_pkg::ST_HDR1;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.out_kind = dweu_pkg::KIND_HEADER;
      case (state_ff)
         dweu_pkg::ST_HDR1, dweu_pkg::ST_HDR2, dweu_pkg::ST_HDR3,
         dweu_pkg::ST_HDR4, dweu_pkg::ST_DATA: req_tready = sts.out_free;
         dweu_pkg::ST_STOP:                    req_tready = 1'b1;
         default:                              req_tready = 1'b0;
      endcase
      in_fire = req_tvalid && req_tready;

      case (state_ff)
         dweu_pkg::ST_HDR1: begin
            if (in_fire) begin
               if (!sts.marker_ok) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = dweu_pkg::KIND_BAD_HEADER;
                  cmd.out_last = 1'b1;
                  state_in     = dweu_pkg::ST_STOP;
               end else begin
                  cmd.hdr1_load = 1'b1;
                  state_in      = dweu_pkg::ST_HDR2;
               end
            end
         end
         dweu_pkg::ST_HDR2: begin
            if (in_fire) begin
               cmd.hdr2_load = 1'b1;
               state_in      = dweu_pkg::ST_DIV;
            end
         end
         dweu_pkg::ST_DIV: begin
            // one quotient bit per cycle
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = dweu_pkg::ST_HDR3;
            end
         end
         dweu_pkg::ST_HDR3: begin
            if (in_fire) begin
               cmd.hdr3_load = 1'b1;
               state_in      = dweu_pkg::ST_HDR4;
            end
         end
         dweu_pkg::ST_HDR4: begin
            if (in_fire) begin
               cmd.hdr4_load = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.out_last  = 1'b1;
               if (sts.nch_zero) begin
                  cmd.out_kind = dweu_pkg::KIND_EMPTY_MASK;
                  state_in     = dweu_pkg::ST_STOP;
               end else begin
                  cmd.out_kind = dweu_pkg::KIND_HEADER;
                  state_in     = sts.wpc_zero ? dweu_pkg::ST_HDR1 : dweu_pkg::ST_DATA;
               end
            end
         end
         dweu_pkg::ST_DATA: begin
            if (in_fire) begin
               cmd.data_load = 1'b1;
               state_in      = dweu_pkg::ST_EMIT;
            end
         end
         dweu_pkg::ST_EMIT: begin
            if (sts.slot_none) begin
               cmd.word_end = 1'b1;
               state_in     = sts.event_end ? dweu_pkg::ST_HDR1 : dweu_pkg::ST_DATA;
            end else if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.overflow) begin
                  cmd.out_kind = dweu_pkg::KIND_OVERFLOW;
                  cmd.out_last = 1'b1;
                  state_in     = dweu_pkg::ST_STOP;
               end else begin
                  cmd.out_kind  = dweu_pkg::KIND_SAMPLE;
                  cmd.out_last  = sts.slot_last;
                  cmd.emit_step = 1'b1;
                  if (sts.slot_last) begin
                     cmd.word_end = 1'b1;
                     state_in     = sts.event_end ? dweu_pkg::ST_HDR1 : dweu_pkg::ST_DATA;
                  end
               end
            end
         end
         dweu_pkg::ST_STOP: begin
            // drop every beat until reset
         end
         default: begin
            state_in = dweu_pkg::ST_HDR1;
         end
      endcase
   end

endmodule

// ===== design/dweu_dp.sv =====
// Datapath of the event word unpacker: header registers, serial divider,
// sample slot extraction and the result register. Uses dweu_pkg.
module dweu_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [dweu_pkg::WORD_W-1:0]    req_tdata,
   input  logic                           csr_valid,
   input  logic [0:0]                     csr_data,
   input  dweu_pkg::cmd_type              cmd,
   output dweu_pkg::sts_type              sts,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [dweu_pkg::RSP_W-1:0]     rsp_tdata,
   output logic [dweu_pkg::KIND_W-1:0]    rsp_tuser,
   output logic                           rsp_tlast
);

   logic                              mode_ff, mode_in;
   logic [dweu_pkg::SIZE_W-1:0]       wpc_ff, wpc_in;
   logic [dweu_pkg::SIZE_W-1:0]       left_ff, left_in;
   logic [dweu_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [dweu_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [dweu_pkg::MASK_W-1:0]       mask_ff, mask_in;
   logic [dweu_pkg::CH_W-1:0]         chan_ff, chan_in;
   logic [dweu_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [dweu_pkg::ID_W-1:0]         id_ff, id_in;
   logic [dweu_pkg::WORD_W-1:0]       stamp_ff, stamp_in;
   logic [dweu_pkg::WORD_W-1:0]       word_ff, word_in;
   logic [1:0]                        k_ff, k_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dweu_pkg::RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [dweu_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [dweu_pkg::NCH_W-1:0]        nch;
   logic [dweu_pkg::NCH_W-1:0]        trial;
   logic                              qbit;
   logic [dweu_pkg::SIZE_W-1:0]       size_field;
   logic [dweu_pkg::SIZE_W-1:0]       payload;
   logic [dweu_pkg::CH_W-1:0]         first_ch;
   logic [dweu_pkg::CH_W-1:0]         next_ch;
   logic                              next_none;
   logic [1:0]                        slot_n;
   logic [dweu_pkg::VAL_W-1:0]        slot_val;

   logic [dweu_pkg::CH_W-1:0]         o_chan;
   logic [dweu_pkg::IDX_W-1:0]        o_idx;
   logic [dweu_pkg::VAL_W-1:0]        o_val;
   logic [dweu_pkg::ID_W-1:0]         o_id;
   logic [dweu_pkg::WORD_W-1:0]       o_stamp;
   logic [dweu_pkg::MASK_W-1:0]       o_mask;

   // channel count and channel search over the held mask
   always_comb begin
      nch       = '0;
      first_ch  = '0;
      next_ch   = '0;
      next_none = 1'b1;
      for (int c = dweu_pkg::MASK_W - 1; c >= 0; c--) begin
         nch = nch + dweu_pkg::NCH_W'(mask_ff[c]);
         if (mask_ff[c]) begin
            first_ch = dweu_pkg::CH_W'(c);
         end
         if (mask_ff[c] && (c > int'(chan_ff))) begin
            next_ch   = dweu_pkg::CH_W'(c);
            next_none = 1'b0;
         end
      end
   end

   // restoring divide step: payload words by channel count
   always_comb begin
      trial = {rem_ff, wpc_ff[dweu_pkg::SIZE_W-1]};
      qbit  = (trial >= nch);
   end

   always_comb begin
      size_field = req_tdata[dweu_pkg::SIZE_W-1:0];
      payload    = (size_field >= dweu_pkg::HDR_WORDS) ? size_field - dweu_pkg::HDR_WORDS : '0;
   end

   // sample slots of the held payload word
   always_comb begin
      slot_n   = mode_ff ? word_ff[31:30] : 2'd2;
      slot_val = '0;
      if (!mode_ff) begin
         slot_val = k_ff[0] ? word_ff[31:16] : word_ff[15:0];
      end else begin
         case (k_ff)
            2'd0:    slot_val = dweu_pkg::VAL_W'(word_ff[9:0]);
            2'd1:    slot_val = dweu_pkg::VAL_W'(word_ff[19:10]);
            2'd2:    slot_val = dweu_pkg::VAL_W'(word_ff[29:20]);
            default: slot_val = '0;
         endcase
      end
   end

   always_comb begin
      sts.marker_ok = (req_tdata[31:28] == dweu_pkg::HDR_MARKER);
      sts.nch_zero  = (nch == '0);
      sts.div_last  = (div_cnt_ff == dweu_pkg::DIV_CNT_W'(dweu_pkg::SIZE_W - 1));
      sts.wpc_zero  = (wpc_ff == '0);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
      sts.slot_none = (slot_n == 2'd0);
      sts.slot_last = (k_ff == slot_n - 2'd1);
      sts.overflow  = (cnt_ff >= dweu_pkg::CNT_W'(dweu_pkg::MAX_SAMPLES));
      sts.event_end = (left_ff == dweu_pkg::SIZE_W'(1)) && next_none;
   end

   // event state registers
   always_comb begin
      mode_in    = mode_ff;
      wpc_in     = wpc_ff;
      left_in    = left_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      mask_in    = mask_ff;
      chan_in    = chan_ff;
      cnt_in     = cnt_ff;
      id_in      = id_ff;
      stamp_in   = stamp_ff;
      word_in    = word_ff;
      k_in       = k_ff;

      if (csr_valid) begin
         mode_in = csr_data[0];
      end
      if (cmd.hdr1_load) begin
         wpc_in = payload;
      end
      if (cmd.hdr2_load) begin
         mask_in    = req_tdata[dweu_pkg::MASK_W-1:0] & dweu_pkg::CH_MASK;
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         wpc_in     = {wpc_ff[dweu_pkg::SIZE_W-2:0], qbit};
         rem_in     = qbit ? dweu_pkg::REM_W'(trial - nch) : dweu_pkg::REM_W'(trial);
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (cmd.hdr3_load) begin
         id_in = req_tdata[dweu_pkg::ID_W-1:0];
      end
      if (cmd.hdr4_load) begin
         stamp_in = req_tdata;
         cnt_in   = '0;
         left_in  = wpc_ff;
         chan_in  = first_ch;
      end
      if (cmd.data_load) begin
         word_in = req_tdata;
         k_in    = '0;
      end
      if (cmd.emit_step) begin
         cnt_in = cnt_ff + 1'b1;
         k_in   = k_ff + 2'd1;
      end
      if (cmd.word_end) begin
         left_in = left_ff - 1'b1;
         // advance to the next enabled channel when this record is done
         if ((left_ff == dweu_pkg::SIZE_W'(1)) && !next_none) begin
            chan_in = next_ch;
            left_in = wpc_ff;
            cnt_in  = '0;
         end
      end
   end

   // result fields
   always_comb begin
      o_chan  = '0;
      o_idx   = '0;
      o_val   = '0;
      o_id    = id_ff;
      o_stamp = stamp_ff;
      o_mask  = mask_ff;
      case (cmd.out_kind)
         dweu_pkg::KIND_HEADER, dweu_pkg::KIND_EMPTY_MASK: begin
            o_stamp = req_tdata;
         end
         dweu_pkg::KIND_SAMPLE: begin
            o_chan = chan_ff;
            o_idx  = dweu_pkg::IDX_W'(cnt_ff);
            o_val  = slot_val;
         end
         dweu_pkg::KIND_OVERFLOW: begin
            o_chan = chan_ff;
            o_idx  = dweu_pkg::IDX_W'(cnt_ff);
         end
         default: begin
            o_id    = '0;
            o_stamp = '0;
            o_mask  = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, o_mask, o_stamp, o_id, o_val, o_idx, o_chan};
         rsp_kind_in  = cmd.out_kind;
         rsp_last_in  = cmd.out_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wpc_ff      <= wpc_in;
      left_ff     <= left_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      mask_ff     <= mask_in;
      chan_ff     <= chan_in;
      cnt_ff      <= cnt_in;
      id_ff       <= id_in;
      stamp_ff    <= stamp_in;
      word_ff     <= word_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== bench/tb.sv =====
// Testbench for digitizer_event_word_unpacker: streams readout events through the block
// and checks every result beat against an in-bench event unpacker.
// Depends on dweu_pkg and the RTL of the block.
module tb;

   typedef enum logic [2:0] {
      EXP_SIZE,
      EXP_MASK,
      EXP_ID,
      EXP_STAMP,
      IN_PAYLOAD,
      HALTED
   } parse_state_type;

   typedef struct {
      logic [dweu_pkg::KIND_W-1:0] kind;
      logic [dweu_pkg::CH_W-1:0]   channel;
      logic [dweu_pkg::IDX_W-1:0]  index;
      logic [dweu_pkg::VAL_W-1:0]  value;
      logic [dweu_pkg::ID_W-1:0]   event_id;
      logic [31:0]                 stamp;
      logic [dweu_pkg::MASK_W-1:0] mask;
      logic                        last;
   } unpack_result_type;

   class readout_scoreboard;
      bit                          packing;
      parse_state_type             state;
      logic [dweu_pkg::SIZE_W-1:0] payload_len;
      logic [dweu_pkg::SIZE_W-1:0] per_channel;
      logic [dweu_pkg::SIZE_W-1:0] words_left;
      logic [dweu_pkg::MASK_W-1:0] mask;
      logic [dweu_pkg::CH_W-1:0]   chan;
      int unsigned                 sample_count;
      logic [dweu_pkg::ID_W-1:0]   event_id;
      logic [31:0]                 stamp;
      unpack_result_type           results_due[$];
      int                          errors;
      int                          checked;
      int                          words;

      function new();
         packing      = 1'b0;
         state        = EXP_SIZE;
         payload_len  = '0;
         per_channel  = '0;
         words_left   = '0;
         mask         = '0;
         chan         = '0;
         sample_count = 0;
         event_id     = '0;
         stamp        = '0;
         errors       = 0;
         checked      = 0;
         words        = 0;
      endfunction

      function void queue_result(dweu_pkg::kind_type kind, int unsigned ch, int unsigned idx,
                                 int unsigned val, bit with_event);
         unpack_result_type r;
         r.kind     = kind;
         r.channel  = dweu_pkg::CH_W'(ch);
         r.index    = dweu_pkg::IDX_W'(idx);
         r.value    = dweu_pkg::VAL_W'(val);
         r.event_id = with_event ? event_id : '0;
         r.stamp    = with_event ? stamp : '0;
         r.mask     = with_event ? mask : '0;
         r.last     = 1'b0;
         results_due.insert(results_due.size(), r);
      endfunction

      function int unsigned next_enabled(int unsigned from);
         int unsigned c;
         for (c = from; c < dweu_pkg::NUM_CHANNELS; c++)
            if (mask[c])
               return c;
         return 8;
      endfunction

      // false once the sample index runs past the record limit
      function bit push_sample(logic [dweu_pkg::VAL_W-1:0] val);
         if (sample_count >= dweu_pkg::MAX_SAMPLES) begin
            queue_result(dweu_pkg::KIND_OVERFLOW, chan, sample_count, 0, 1'b1);
            state = HALTED;
            return 1'b0;
         end
         queue_result(dweu_pkg::KIND_SAMPLE, chan, sample_count, val, 1'b1);
         sample_count++;
         return 1'b1;
      endfunction

      function void unpack_word(logic [31:0] w);
         int          first;
         int unsigned nch;
         int unsigned nx;
         int unsigned i;
         bit          ok;
         first = results_due.size();
         words++;
         case (state)
            EXP_SIZE: begin
               if (w[31:28] != dweu_pkg::HDR_MARKER) begin
                  queue_result(dweu_pkg::KIND_BAD_HEADER, 0, 0, 0, 1'b0);
                  state = HALTED;
               end else begin
                  payload_len = (w[27:0] >= 28'd4) ? dweu_pkg::SIZE_W'(w[27:0] - 28'd4) : '0;
                  state = EXP_MASK;
               end
            end
            EXP_MASK: begin
               mask  = w[7:0] & dweu_pkg::CH_MASK;
               state = EXP_ID;
            end
            EXP_ID: begin
               event_id = w[dweu_pkg::ID_W-1:0];
               state    = EXP_STAMP;
            end
            EXP_STAMP: begin
               nch   = $countones(mask);
               stamp = w;
               if (nch == 0) begin
                  queue_result(dweu_pkg::KIND_EMPTY_MASK, 0, 0, 0, 1'b1);
                  state = HALTED;
               end else begin
                  per_channel = dweu_pkg::SIZE_W'(payload_len / nch);
                  queue_result(dweu_pkg::KIND_HEADER, 0, 0, 0, 1'b1);
                  sample_count = 0;
                  words_left   = per_channel;
                  chan         = dweu_pkg::CH_W'(next_enabled(0));
                  state        = (per_channel != 0) ? IN_PAYLOAD : EXP_SIZE;
               end
            end
            IN_PAYLOAD: begin
               ok = 1'b1;
               if (!packing) begin
                  ok = push_sample(w[15:0]);
                  if (ok)
                     ok = push_sample(w[31:16]);
               end else begin
                  for (i = 0; i < w[31:30] && ok; i++)
                     ok = push_sample(dweu_pkg::VAL_W'((w >> (10 * i)) & 32'h3FF));
               end
               if (ok) begin
                  if (words_left != 0)
                     words_left--;
                  if (words_left == 0) begin
                     nx = next_enabled(int'(chan) + 1);
                     if (nx >= 8) begin
                        state = EXP_SIZE;
                     end else begin
                        chan         = dweu_pkg::CH_W'(nx);
                        words_left   = per_channel;
                        sample_count = 0;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (results_due.size() > first)
            results_due[results_due.size() - 1].last = 1'b1;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 100)
               $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      function void check_result(logic [dweu_pkg::KIND_W-1:0] kind,
                                 logic [dweu_pkg::RSP_W-1:0] data, logic last);
         unpack_result_type e;
         checked++;
         if (results_due.size() == 0) begin
            errors++;
            if (errors <= 100)
               $error("result beat with nothing expected, kind 0x%0h", kind);
            return;
         end
         e = results_due.pop_front();
         compare("kind", 32'(e.kind), 32'(kind));
         compare("channel", 32'(e.channel), 32'(data[2:0]));
         compare("sample_index", 32'(e.index), 32'(data[18:3]));
         compare("sample_value", 32'(e.value), 32'(data[34:19]));
         compare("event_id", 32'(e.event_id), 32'(data[57:35]));
         compare("time_stamp", e.stamp, data[89:58]);
         compare("channel_mask", 32'(e.mask), 32'(data[97:90]));
         compare("last", 32'(e.last), 32'(last));
      endfunction
   endclass

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [dweu_pkg::WORD_W-1:0]   req_tdata  = '0;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [0:0]                    csr_data   = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [dweu_pkg::RSP_W-1:0]    rsp_tdata;
   logic [dweu_pkg::KIND_W-1:0]   rsp_tuser;
   logic                          rsp_tlast;

   readout_scoreboard   board = new();
   int                  send_gap_pct  = 6;
   int                  rsp_stall_pct = 76;
   int unsigned         word_count    = 0;

   digitizer_event_word_unpacker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.packing = csr_data[0];
         if (req_tvalid && req_tready)
            board.unpack_word(req_tdata);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_word(input logic [31:0] w);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      word_count++;
   endtask

   task automatic send_header(input logic [dweu_pkg::SIZE_W-1:0] size,
                              input logic [dweu_pkg::MASK_W-1:0] mask,
                              input logic [dweu_pkg::ID_W-1:0] id, input logic [31:0] stamp);
      send_word({dweu_pkg::HDR_MARKER, size});
      send_word({24'($urandom), mask});
      send_word({9'($urandom), id});
      send_word(stamp);
   endtask

   // drain all results, then cover words that produce nothing (divide, empty count)
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.results_due.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_event();
      logic [dweu_pkg::MASK_W-1:0] m;
      logic [dweu_pkg::SIZE_W-1:0] size;
      int unsigned                 nch;
      int unsigned                 wpc;
      m = dweu_pkg::MASK_W'($urandom_range(255, 1));
      if ($urandom_range(3) == 0)
         m = dweu_pkg::MASK_W'(1) << $urandom_range(7);
      nch = $countones(m);
      wpc = ($urandom_range(99) < 15) ? 0 : $urandom_range(4, 1);
      // add a random remainder to the size so the per-channel divide can truncate
      if (wpc == 0 && $urandom_range(1) == 1)
         size = dweu_pkg::SIZE_W'($urandom_range(3));
      else
         size = dweu_pkg::SIZE_W'(4 + nch * wpc + $urandom_range(nch - 1));
      send_header(size, m, dweu_pkg::ID_W'($urandom), $urandom);
      repeat (nch * wpc) send_word($urandom);
   endtask

   task automatic random_block(input int unsigned count);
      int unsigned stop_at;
      stop_at = word_count + count;
      while (word_count < stop_at) begin
         if ($urandom_range(3) == 0)
            write_mode(1'($urandom_range(1)));
         random_event();
      end
   endtask

   initial begin
      int          end_case;
      int unsigned drain;
      logic [3:0]  nib;
      string       end_name;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      // short size: header only
      send_header(28'd3, 8'hFF, 23'h7FFFFF, 32'hFFFF_FFFF);
      // size above four but less than one word per channel
      send_header(28'd7, 8'h0F, 23'd0, 32'd0);
      // two channels at the mask ends, one remainder word not sent
      send_header(28'd9, 8'h81, 23'h2AAAAA, 32'h8000_0001);
      send_word(32'h0000_FFFF);
      send_word(32'hFFFF_0000);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      write_mode(1'b1);
      send_header(28'd8, 8'h10, 23'h155555, 32'h7FFF_FFFF);
      send_word({2'd1, 30'h3FFF_FFFF});
      send_word({2'd2, 30'h2AAA_AAAA});
      send_word({2'd3, 30'h3FFF_FFFF});
      send_word({2'd0, 30'h3FFF_FFFF});

      random_block(30);
      send_gap_pct  = 76;
      rsp_stall_pct = 6;
      random_block(30);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      random_block(30);

      // any error halts the block until reset, so only one kind closes a run
      end_case = $urandom_range(1);
      case (end_case)
         0: begin
            end_name = "bad header";
            do nib = 4'($urandom); while (nib == dweu_pkg::HDR_MARKER);
            send_word({nib, 28'($urandom)});
         end
         default: begin
            end_name = "empty mask";
            send_header(dweu_pkg::SIZE_W'($urandom), 8'h00, dweu_pkg::ID_W'($urandom),
                        $urandom);
         end
      endcase
      // drop these: the block is halted
      repeat (3) send_word($urandom);

      req_tvalid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (board.results_due.size() != 0 && drain < 20000);
      repeat (40) @(posedge clock);
      if (board.results_due.size() != 0) begin
         board.errors += board.results_due.size();
         $error("%0d expected results never arrived", board.results_due.size());
      end

      $display("tb: %0d words accepted, %0d result beats checked over both packing modes",
               board.words, board.checked);
      $display("tb: run closed on a %s error, later words dropped", end_name);
      if (board.errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end
endmodule
